// ===== rtl/core/pass_dependency_topo_sort_assert.svh =====
// ----------------------------------------------------------------------------
// pass_dependency_topo_sort_assert
// assertion macros shared by the pass sorter rtl
// ----------------------------------------------------------------------------
`ifndef PASS_DEPENDENCY_TOPO_SORT_ASSERT_SVH
`define PASS_DEPENDENCY_TOPO_SORT_ASSERT_SVH

// same-cycle implication
`define PDTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PDTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/pdts_pkg.sv =====
// ----------------------------------------------------------------------------
// pdts_pkg
// shared types and constants of the pass dependency sorter
// ----------------------------------------------------------------------------
package pdts_pkg;

   localparam int MAX_PASSES_DEF    = 32;
   localparam int MAX_RESOURCES_DEF = 64;
   localparam int MAX_DEPS_DEF      = 256;

   // access codes above this select the buffer space
   localparam logic [3:0] TEXTURE_KIND_MAX = 4'd10;

   typedef enum logic [2:0] {
      CMD_CLEAR     = 3'd0,
      CMD_ADD_PASS  = 3'd1,
      CMD_ADD_READ  = 3'd2,
      CMD_ADD_WRITE = 3'd3,
      CMD_COMPILE   = 3'd4
   } cmd_type;

endpackage

// ===== rtl/core/pass_dependency_topo_sort.sv =====
// ----------------------------------------------------------------------------
// pass_dependency_topo_sort
// render pass graph loader and kahn topological sorter
// ----------------------------------------------------------------------------
// load commands (clear, add pass, add read, add write) complete while busy stays low
// compile: builds the edges, seeds the ready queue with the passes that have no
//   incoming edge, sorts, then reads and emits each result in turn
// empty compile: its single result follows in the cycle after the transfer
// throughput is set by the single shared memory read port of each store
// reset (synchronous) empties the graph; results cannot be stalled by the receiver
`include "pass_dependency_topo_sort_assert.svh"

module pass_dependency_topo_sort #(
   parameter int MAX_PASSES    = pdts_pkg::MAX_PASSES_DEF,
   parameter int MAX_RESOURCES = pdts_pkg::MAX_RESOURCES_DEF,
   parameter int MAX_DEPS      = pdts_pkg::MAX_DEPS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_command,
   input  logic [4:0] req_pass_id,
   input  logic [5:0] req_resource_id,
   input  logic [3:0] req_access_kind,
   output logic       rsp_valid,
   output logic [4:0] rsp_pass_index,
   output logic       rsp_last,
   output logic       rsp_empty_res,
   output logic       rsp_fallback
);

   import pdts_pkg::*;

   // widths
   localparam int PW   = $clog2(MAX_PASSES);        // pass index
   localparam int PCW  = $clog2(MAX_PASSES + 1);    // pass count
   localparam int RW   = $clog2(MAX_RESOURCES);     // resource index
   localparam int CW   = $clog2(MAX_DEPS + 1);      // dep / edge count
   localparam int DAW  = $clog2(MAX_DEPS);          // dep / edge address
   localparam int DEPW = PW + RW + 2;               // {write, buffer, res, pass}
   localparam int EW   = 2 * PW;                    // {source, target}
   localparam int WD   = 2 * MAX_RESOURCES;         // last writer entries
   localparam int WAW  = RW + 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_B_DRD, ST_B_DCHK, ST_B_WCHK, ST_B_PEND,
      ST_K_IRD, ST_K_ICHK, ST_K_QRD, ST_K_QCHK, ST_K_ERD, ST_K_ECHK, ST_K_CCHK,
      ST_O_RD, ST_O_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [PCW-1:0]   pcount_ff, pcount_in;
   logic [CW-1:0]    dcount_ff, dcount_in;
   logic [CW-1:0]    ecount_ff, ecount_in;
   logic [CW-1:0]    didx_ff, didx_in;
   logic [PCW-1:0]   pidx_ff, pidx_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             phase_wr_ff, phase_wr_in;
   logic [PCW-1:0]   head_ff, head_in;
   logic [PCW-1:0]   tail_ff, tail_in;
   logic [PW-1:0]    cur_ff, cur_in;
   logic             fb_ff, fb_in;
   logic             wv_ff, wv_in;
   logic [WD-1:0]    wvalid_ff, wvalid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [4:0]       rsp_pass_ff, rsp_pass_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_empty_ff, rsp_empty_in;
   logic             rsp_fb_ff, rsp_fb_in;

   // memory ports
   logic             dep_we;
   logic [DEPW-1:0]  dep_wdata, dep_rdata;
   logic             edge_we;
   logic [EW-1:0]    edge_wdata, edge_rdata;
   logic             wr_we;
   logic [WAW-1:0]   wr_waddr, wr_raddr;
   logic [PW-1:0]    wr_rdata;
   logic             inc_we;
   logic [PW-1:0]    inc_waddr, inc_raddr;
   logic [CW-1:0]    inc_wdata, inc_rdata;
   logic             q_we;
   logic [PW-1:0]    q_waddr, q_raddr, q_wdata, q_rdata;

   // dependency entry fields
   logic [PW-1:0]    d_pass;
   logic             d_wr;
   logic [PW-1:0]    e_src, e_dst;
   logic             accept;

   assign d_pass   = dep_rdata[PW-1:0];
   assign wr_raddr = dep_rdata[DEPW-2:PW];         // {buffer, resource}
   assign d_wr     = dep_rdata[DEPW-1];
   assign e_src    = edge_rdata[EW-1:PW];
   assign e_dst    = edge_rdata[PW-1:0];
   assign accept   = start && (state_ff == ST_IDLE);

   assign busy     = (state_ff != ST_IDLE);

   // read address selection
   assign inc_raddr = (state_ff == ST_K_IRD) ? pidx_ff[PW-1:0] : e_dst;
   assign q_raddr   = (state_ff == ST_O_RD) ? pidx_ff[PW-1:0] : head_ff[PW-1:0];

   always_comb begin
      state_in     = state_ff;
      pcount_in    = pcount_ff;
      dcount_in    = dcount_ff;
      ecount_in    = ecount_ff;
      didx_in      = didx_ff;
      pidx_in      = pidx_ff;
      cnt_in       = cnt_ff;
      phase_wr_in  = phase_wr_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cur_in       = cur_ff;
      fb_in        = fb_ff;
      wv_in        = wv_ff;
      wvalid_in    = wvalid_ff;
      rsp_valid_in = 1'b0;
      rsp_pass_in  = rsp_pass_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_fb_in    = rsp_fb_ff;
      dep_we       = 1'b0;
      dep_wdata    = {1'b0, 1'b0, RW'(req_resource_id), PW'(req_pass_id)};
      edge_we      = 1'b0;
      edge_wdata   = {wr_rdata, pidx_ff[PW-1:0]};
      wr_we        = 1'b0;
      wr_waddr     = wr_raddr;
      inc_we       = 1'b0;
      inc_waddr    = pidx_ff[PW-1:0];
      inc_wdata    = cnt_ff;
      q_we         = 1'b0;
      q_waddr      = tail_ff[PW-1:0];
      q_wdata      = pidx_ff[PW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd_type'(req_command))
                  CMD_CLEAR: begin
                     pcount_in = '0;
                     dcount_in = '0;
                  end
                  CMD_ADD_PASS: begin
                     if (pcount_ff < PCW'(MAX_PASSES)) begin
                        pcount_in = pcount_ff + 1'b1;
                     end
                  end
                  CMD_ADD_READ, CMD_ADD_WRITE: begin
                     // unknown pass, out-of-range resource or full store: dropped
                     dep_wdata = {(cmd_type'(req_command) == CMD_ADD_WRITE),
                                  (req_access_kind > TEXTURE_KIND_MAX),
                                  RW'(req_resource_id), PW'(req_pass_id)};
                     if ((8'(req_pass_id) < 8'(pcount_ff)) &&
                         (9'(req_resource_id) < 9'(MAX_RESOURCES)) &&
                         (dcount_ff < CW'(MAX_DEPS))) begin
                        dep_we    = 1'b1;
                        dcount_in = dcount_ff + 1'b1;
                     end
                  end
                  CMD_COMPILE: begin
                     wvalid_in = '0;
                     if (pcount_ff == '0) begin
                        // empty graph: single flagged result
                        rsp_valid_in = 1'b1;
                        rsp_pass_in  = '0;
                        rsp_last_in  = 1'b1;
                        rsp_empty_in = 1'b1;
                        rsp_fb_in    = 1'b0;
                     end else begin
                        pidx_in     = '0;
                        didx_in     = '0;
                        cnt_in      = '0;
                        phase_wr_in = 1'b0;
                        ecount_in   = '0;
                        state_in    = ST_B_DRD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // edge build: per pass, a read sweep then a write sweep over the deps
         ST_B_DRD: begin
            if (didx_ff == dcount_ff) begin
               if (!phase_wr_ff) begin
                  phase_wr_in = 1'b1;
                  didx_in     = '0;
               end else begin
                  state_in = ST_B_PEND;
               end
            end else begin
               state_in = ST_B_DCHK;
            end
         end
         ST_B_DCHK: begin
            if ((d_pass == pidx_ff[PW-1:0]) && (d_wr == phase_wr_ff)) begin
               if (phase_wr_ff) begin
                  wr_we               = 1'b1;
                  wvalid_in[wr_raddr] = 1'b1;
                  didx_in             = didx_ff + 1'b1;
                  state_in            = ST_B_DRD;
               end else begin
                  wv_in    = wvalid_ff[wr_raddr];
                  state_in = ST_B_WCHK;
               end
            end else begin
               didx_in  = didx_ff + 1'b1;
               state_in = ST_B_DRD;
            end
         end
         ST_B_WCHK: begin
            if (wv_ff && (wr_rdata != pidx_ff[PW-1:0]) && (ecount_ff < CW'(MAX_DEPS))) begin
               edge_we   = 1'b1;
               ecount_in = ecount_ff + 1'b1;
               cnt_in    = cnt_ff + 1'b1;
            end
            didx_in  = didx_ff + 1'b1;
            state_in = ST_B_DRD;
         end
         ST_B_PEND: begin
            inc_we      = 1'b1;
            cnt_in      = '0;
            phase_wr_in = 1'b0;
            didx_in     = '0;
            if (PCW'(pidx_ff + 1'b1) == pcount_ff) begin
               pidx_in  = '0;
               head_in  = '0;
               tail_in  = '0;
               state_in = ST_K_IRD;
            end else begin
               pidx_in  = pidx_ff + 1'b1;
               state_in = ST_B_DRD;
            end
         end
         // seed the ready queue with passes that have no incoming edge
         ST_K_IRD: begin
            if (pidx_ff == pcount_ff) begin
               head_in  = '0;
               state_in = ST_K_QRD;
            end else begin
               state_in = ST_K_ICHK;
            end
         end
         ST_K_ICHK: begin
            if (inc_rdata == '0) begin
               q_we    = 1'b1;
               tail_in = tail_ff + 1'b1;
            end
            pidx_in  = pidx_ff + 1'b1;
            state_in = ST_K_IRD;
         end
         ST_K_QRD: begin
            if (head_ff == tail_ff) begin
               pidx_in  = '0;
               fb_in    = (tail_ff != pcount_ff);
               state_in = ST_O_RD;
            end else begin
               state_in = ST_K_QCHK;
            end
         end
         ST_K_QCHK: begin
            cur_in   = q_rdata;
            head_in  = head_ff + 1'b1;
            didx_in  = '0;
            state_in = ST_K_ERD;
         end
         ST_K_ERD: begin
            if (didx_ff == ecount_ff) begin
               state_in = ST_K_QRD;
            end else begin
               state_in = ST_K_ECHK;
            end
         end
         ST_K_ECHK: begin
            if (e_src == cur_ff) begin
               state_in = ST_K_CCHK;
            end else begin
               didx_in  = didx_ff + 1'b1;
               state_in = ST_K_ERD;
            end
         end
         ST_K_CCHK: begin
            inc_waddr = e_dst;
            inc_wdata = inc_rdata - 1'b1;
            q_wdata   = e_dst;
            if (inc_rdata != '0) begin
               inc_we = 1'b1;
               if (inc_rdata == CW'(1)) begin
                  q_we    = 1'b1;
                  tail_in = tail_ff + 1'b1;
               end
            end
            didx_in  = didx_ff + 1'b1;
            state_in = ST_K_ERD;
         end
         // result transfers: sorted order, or insertion order on a cycle
         ST_O_RD: begin
            state_in = ST_O_EMIT;
         end
         ST_O_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_pass_in  = fb_ff ? 5'(pidx_ff) : 5'(q_rdata);
            rsp_last_in  = (PCW'(pidx_ff + 1'b1) == pcount_ff);
            rsp_empty_in = 1'b0;
            rsp_fb_in    = fb_ff;
            pidx_in      = pidx_ff + 1'b1;
            state_in     = (PCW'(pidx_ff + 1'b1) == pcount_ff) ? ST_IDLE : ST_O_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pcount_ff    <= '0;
         dcount_ff    <= '0;
         ecount_ff    <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         wvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pcount_ff    <= pcount_in;
         dcount_ff    <= dcount_in;
         ecount_ff    <= ecount_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         wvalid_ff    <= wvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      didx_ff     <= didx_in;
      pidx_ff     <= pidx_in;
      cnt_ff      <= cnt_in;
      phase_wr_ff <= phase_wr_in;
      cur_ff      <= cur_in;
      fb_ff       <= fb_in;
      wv_ff       <= wv_in;
      rsp_pass_ff  <= rsp_pass_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_fb_ff    <= rsp_fb_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pass_index = rsp_pass_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_empty_res  = rsp_empty_ff;
   assign rsp_fallback   = rsp_fb_ff;

   // dependency store
   pdts_ram #(.WIDTH(DEPW), .DEPTH(MAX_DEPS)) u_dep_ram (
      .clock   (clock),
      .wr_en   (dep_we),
      .wr_addr (dcount_ff[DAW-1:0]),
      .wr_data (dep_wdata),
      .rd_addr (didx_ff[DAW-1:0]),
      .rd_data (dep_rdata)
   );

   // edge store
   pdts_ram #(.WIDTH(EW), .DEPTH(MAX_DEPS)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (ecount_ff[DAW-1:0]),
      .wr_data (edge_wdata),
      .rd_addr (didx_ff[DAW-1:0]),
      .rd_data (edge_rdata)
   );

   // last writer per {space, resource}, validity kept in wvalid_ff
   pdts_ram #(.WIDTH(PW), .DEPTH(WD)) u_writer_ram (
      .clock   (clock),
      .wr_en   (wr_we),
      .wr_addr (wr_waddr),
      .wr_data (pidx_ff[PW-1:0]),
      .rd_addr (wr_raddr),
      .rd_data (wr_rdata)
   );

   // incoming edge counts
   pdts_ram #(.WIDTH(CW), .DEPTH(MAX_PASSES)) u_inc_ram (
      .clock   (clock),
      .wr_en   (inc_we),
      .wr_addr (inc_waddr),
      .wr_data (inc_wdata),
      .rd_addr (inc_raddr),
      .rd_data (inc_rdata)
   );

   // ready queue, also holds the final order
   pdts_ram #(.WIDTH(PW), .DEPTH(MAX_PASSES)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   `PDTS_ASSERT_NOW(a_empty_is_last, clock, reset,
      rsp_valid_ff && rsp_empty_ff, rsp_last_ff, "empty result not last")
   `PDTS_ASSERT_NOW(a_pass_in_range, clock, reset,
      rsp_valid_ff && !rsp_empty_ff, 8'(rsp_pass_ff) < 8'(pcount_ff),
      "result pass out of range")
   `PDTS_ASSERT_NOW(a_queue_order, clock, reset,
      1'b1, head_ff <= tail_ff && tail_ff <= PCW'(MAX_PASSES),
      "ready queue pointers crossed")
   `PDTS_ASSERT_NOW(a_last_frees, clock, reset,
      rsp_valid_ff && rsp_last_ff, state_ff == ST_IDLE, "busy at final result")

endmodule

// ===== rtl/core/pdts_ram.sv =====
// ----------------------------------------------------------------------------
// pdts_ram
// simple dual port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pdts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
